### src/scs_pkg.sv
// Shared types and constants for the spin cycle sequencer.
`timescale 1ns / 1ps

package scs_pkg;

  // Sprint table depth
  localparam int MAX_SPRINTS = 8;
  localparam logic [4:0] MAX_SPR5 = 5'(MAX_SPRINTS);

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_START  = 3'd1,
    KIND_PAUSE  = 3'd2,
    KIND_RESUME = 3'd3,
    KIND_STOP   = 3'd4,
    KIND_LOAD   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CLUTCH   = 4'd1,
    PH_SPR_ON   = 4'd2,
    PH_SPR_OFF  = 4'd3,
    PH_DUTY_ON  = 4'd4,
    PH_DUTY_OFF = 4'd5,
    PH_COAST    = 4'd6,
    PH_PCOAST   = 4'd7,
    PH_SCOAST   = 4'd8,
    PH_RCOAST   = 4'd9,
    PH_PAUSED   = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    CFG_CLUTCH_WAIT = 3'd0,
    CFG_DUTY_ON     = 3'd1,
    CFG_DUTY_OFF    = 3'd2,
    CFG_COAST       = 3'd3,
    CFG_RETRY_LIMIT = 3'd4,
    CFG_SPR_TOTAL   = 3'd5,
    CFG_MON_EN      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       motor_run;
    logic       pump_run;
    logic [3:0] phase;
    logic       active;
    logic       paused;
    logic       finished;
    logic       fault;
    logic       monitor_clear;
  } res_t;

endpackage

### src/spin_cycle_sequencer.sv
// Spin cycle sequencer top level: command decode, phase sequencing, result buffer.
`timescale 1ns / 1ps

// Usage:
// - Command channel (in_valid_i/in_ready_o): one beat per command with a
//   millisecond timestamp; ticks drive all timed phase transitions.
// - Result channel (out_valid_o/out_ready_i): exactly one beat per command,
//   giving drive outputs, phase and flags after that command.
// - Config channel (cfg_valid_i/cfg_ready_o): register index plus data, always
//   ready; write only while no command is in flight.
// - Latency: a result is valid the cycle after its command beat when the
//   output register is empty or being read that cycle; otherwise it waits.
// - Throughput: one command per cycle while in_ready_o is high; the whole state
//   update is one compare-and-select stage into the state and result registers.
// - A two-entry result buffer (output register plus skid) keeps taking a
//   command while one result waits; in_ready_o drops only when both are full.
// - Reset: sequencer idle, flags clear, sprint table zero, config registers
//   at their defaults, result buffer empty.
module spin_cycle_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // command
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] now_ms_i,
  input  logic        unbalance_i,
  input  logic [15:0] run_seconds_i,
  input  logic [2:0]  entry_index_i,
  input  logic [15:0] entry_on_ms_i,
  input  logic [15:0] entry_off_ms_i,
  // result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        motor_run_o,
  output logic        pump_run_o,
  output logic [3:0]  phase_o,
  output logic        active_o,
  output logic        paused_o,
  output logic        finished_o,
  output logic        fault_o,
  output logic        monitor_clear_o
);
  import scs_pkg::*;

  // config registers
  logic [15:0] clutch_wait_q, duty_on_q, duty_off_q, coast_q;
  logic [3:0]  retry_limit_q, spr_total_q;
  logic        mon_en_q;

  // sequencer state
  phase_e      phase_q, phase_d;
  logic        resume_q, resume_d;
  logic [3:0]  spos_q, spos_d;
  logic [15:0] cur_on_q, cur_on_d, cur_off_q, cur_off_d;
  logic [31:0] pstart_q, pstart_d, dstart_q, dstart_d;
  logic [31:0] dspent_q, dspent_d, dlimit_q, dlimit_d;
  logic [3:0]  retry_q, retry_d;
  logic        motor_q, motor_d, pump_q, pump_d, active_q, active_d;
  logic        paused_q, paused_d, finished_q, finished_d, fault_q, fault_d;
  logic [15:0] on_tbl_q [MAX_SPRINTS];
  logic [15:0] off_tbl_q [MAX_SPRINTS];
  logic        load_en;
  logic        clear;

  // result buffer
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, res;

  logic        push, pop;
  logic [31:0] el, duty_tot;
  logic [4:0]  eff_total, pos_inc;
  logic [3:0]  nxt_pos;
  logic [15:0] nxt_on, nxt_off;
  logic        spinning, in_duty;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_v_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_v_q && out_ready_i;

  always_comb begin
    eff_total = ({1'b0, spr_total_q} > MAX_SPR5) ? MAX_SPR5 : {1'b0, spr_total_q};
    nxt_pos   = spos_q + 4'd1;
    pos_inc   = {1'b0, spos_q} + 5'd1;
    nxt_on    = '0;
    nxt_off   = '0;
    for (int i = 0; i < MAX_SPRINTS; i++) begin
      if (int'(nxt_pos) == i) begin
        nxt_on  = on_tbl_q[i];
        nxt_off = off_tbl_q[i];
      end
    end
    el       = now_ms_i - pstart_q;
    duty_tot = dspent_q + (now_ms_i - dstart_q);
    in_duty  = (phase_q == PH_DUTY_ON) || (phase_q == PH_DUTY_OFF);
    spinning = (phase_q == PH_SPR_ON) || (phase_q == PH_SPR_OFF) || in_duty;
  end

  always_comb begin
    phase_d    = phase_q;
    resume_d   = resume_q;
    spos_d     = spos_q;
    cur_on_d   = cur_on_q;
    cur_off_d  = cur_off_q;
    pstart_d   = pstart_q;
    dstart_d   = dstart_q;
    dspent_d   = dspent_q;
    dlimit_d   = dlimit_q;
    retry_d    = retry_q;
    motor_d    = motor_q;
    pump_d     = pump_q;
    active_d   = active_q;
    paused_d   = paused_q;
    finished_d = finished_q;
    fault_d    = fault_q;
    load_en    = 1'b0;
    clear      = 1'b0;

    case (kind_e'(kind_i))
      KIND_TICK: begin
        if (active_q) begin
          if (mon_en_q && unbalance_i && spinning) begin
            motor_d  = 1'b0;
            pstart_d = now_ms_i;
            if (retry_q < retry_limit_q) begin
              retry_d = retry_q + 4'd1;
              phase_d = PH_RCOAST;
            end else begin
              fault_d = 1'b1;
              phase_d = PH_SCOAST;
            end
          end else begin
            case (phase_q)
              PH_CLUTCH: begin
                if (el >= {16'd0, clutch_wait_q}) begin
                  phase_d  = resume_q ? PH_DUTY_ON : PH_SPR_ON;
                  pstart_d = now_ms_i;
                  if (resume_q) dstart_d = now_ms_i;
                  motor_d = 1'b1;
                end
              end
              PH_SPR_ON: begin
                if (el >= {16'd0, cur_on_q}) begin
                  motor_d  = 1'b0;
                  phase_d  = PH_SPR_OFF;
                  pstart_d = now_ms_i;
                end
              end
              PH_SPR_OFF: begin
                if (el >= {16'd0, cur_off_q}) begin
                  spos_d   = nxt_pos;
                  pstart_d = now_ms_i;
                  motor_d  = 1'b1;
                  if (pos_inc >= eff_total) begin
                    phase_d  = PH_DUTY_ON;
                    resume_d = 1'b1;
                    dstart_d = now_ms_i;
                  end else begin
                    cur_on_d  = nxt_on;
                    cur_off_d = nxt_off;
                    phase_d   = PH_SPR_ON;
                  end
                end
              end
              PH_DUTY_ON, PH_DUTY_OFF: begin
                if (duty_tot >= dlimit_q) begin
                  motor_d  = 1'b0;
                  phase_d  = PH_COAST;
                  pstart_d = now_ms_i;
                end else if (phase_q == PH_DUTY_ON) begin
                  if (el >= {16'd0, duty_on_q}) begin
                    motor_d  = 1'b0;
                    phase_d  = PH_DUTY_OFF;
                    pstart_d = now_ms_i;
                  end
                end else if (el >= {16'd0, duty_off_q}) begin
                  motor_d  = 1'b1;
                  phase_d  = PH_DUTY_ON;
                  pstart_d = now_ms_i;
                end
              end
              PH_COAST: begin
                if (el >= {16'd0, coast_q}) begin
                  motor_d    = 1'b0;
                  pump_d     = 1'b0;
                  phase_d    = PH_IDLE;
                  active_d   = 1'b0;
                  paused_d   = 1'b0;
                  finished_d = 1'b1;
                end
              end
              PH_PCOAST: begin
                if (el >= {16'd0, coast_q}) begin
                  pump_d   = 1'b0;
                  phase_d  = PH_PAUSED;
                  paused_d = 1'b1;
                end
              end
              PH_SCOAST: begin
                if (el >= {16'd0, coast_q}) begin
                  motor_d  = 1'b0;
                  pump_d   = 1'b0;
                  phase_d  = PH_IDLE;
                  active_d = 1'b0;
                  paused_d = 1'b0;
                end
              end
              PH_RCOAST: begin
                if (el >= {16'd0, coast_q}) begin
                  spos_d = 4'd0;
                  if (eff_total != 5'd0) begin
                    cur_on_d  = on_tbl_q[0];
                    cur_off_d = off_tbl_q[0];
                  end
                  phase_d  = PH_CLUTCH;
                  pstart_d = now_ms_i;
                  resume_d = 1'b0;
                  clear    = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      KIND_START: begin
        dlimit_d = {16'd0, run_seconds_i} * {22'd0, MS_PER_S};
        spos_d   = 4'd0;
        if (eff_total != 5'd0) begin
          cur_on_d  = on_tbl_q[0];
          cur_off_d = off_tbl_q[0];
        end else begin
          cur_on_d  = '0;
          cur_off_d = '0;
        end
        active_d   = 1'b1;
        paused_d   = 1'b0;
        finished_d = 1'b0;
        fault_d    = 1'b0;
        retry_d    = 4'd0;
        dspent_d   = '0;
        clear      = 1'b1;
        pump_d     = 1'b1;
        motor_d    = 1'b0;
        phase_d    = PH_CLUTCH;
        pstart_d   = now_ms_i;
        resume_d   = 1'b0;
      end
      KIND_PAUSE: begin
        if (active_q && !paused_q && phase_q != PH_PCOAST) begin
          if (phase_q == PH_CLUTCH) begin
            pump_d   = 1'b0;
            phase_d  = PH_PAUSED;
            paused_d = 1'b1;
          end else begin
            if (in_duty) begin
              dspent_d = duty_tot;
              resume_d = 1'b1;
            end
            motor_d  = 1'b0;
            phase_d  = PH_PCOAST;
            pstart_d = now_ms_i;
          end
        end
      end
      KIND_RESUME: begin
        if (active_q && (paused_q || phase_q == PH_PCOAST)) begin
          pump_d   = 1'b1;
          paused_d = 1'b0;
          phase_d  = PH_CLUTCH;
          pstart_d = now_ms_i;
        end
      end
      KIND_STOP: begin
        if (active_q) begin
          motor_d = 1'b0;
          if (phase_q == PH_CLUTCH || phase_q == PH_PAUSED) begin
            pump_d   = 1'b0;
            phase_d  = PH_IDLE;
            active_d = 1'b0;
            paused_d = 1'b0;
          end else begin
            phase_d  = PH_SCOAST;
            pstart_d = now_ms_i;
          end
        end
      end
      KIND_LOAD: begin
        load_en = !active_q && ({2'd0, entry_index_i} < MAX_SPR5);
      end
      default: begin
      end
    endcase

    res.motor_run     = motor_d;
    res.pump_run      = pump_d;
    res.phase         = phase_d;
    res.active        = active_d;
    res.paused        = paused_d;
    res.finished      = finished_d;
    res.fault         = fault_d;
    res.monitor_clear = clear;
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clutch_wait_q <= 16'd500;
      duty_on_q     <= 16'd10000;
      duty_off_q    <= 16'd2000;
      coast_q       <= 16'd5000;
      retry_limit_q <= 4'd3;
      spr_total_q   <= 4'd0;
      mon_en_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLUTCH_WAIT: clutch_wait_q <= cfg_data_i;
        CFG_DUTY_ON:     duty_on_q     <= cfg_data_i;
        CFG_DUTY_OFF:    duty_off_q    <= cfg_data_i;
        CFG_COAST:       coast_q       <= cfg_data_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        CFG_SPR_TOTAL:   spr_total_q   <= cfg_data_i[3:0];
        CFG_MON_EN:      mon_en_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state, updated on each command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      resume_q   <= 1'b0;
      spos_q     <= '0;
      cur_on_q   <= '0;
      cur_off_q  <= '0;
      pstart_q   <= '0;
      dstart_q   <= '0;
      dspent_q   <= '0;
      dlimit_q   <= '0;
      retry_q    <= '0;
      motor_q    <= 1'b0;
      pump_q     <= 1'b0;
      active_q   <= 1'b0;
      paused_q   <= 1'b0;
      finished_q <= 1'b0;
      fault_q    <= 1'b0;
      for (int i = 0; i < MAX_SPRINTS; i++) begin
        on_tbl_q[i]  <= '0;
        off_tbl_q[i] <= '0;
      end
    end else if (push) begin
      phase_q    <= phase_d;
      resume_q   <= resume_d;
      spos_q     <= spos_d;
      cur_on_q   <= cur_on_d;
      cur_off_q  <= cur_off_d;
      pstart_q   <= pstart_d;
      dstart_q   <= dstart_d;
      dspent_q   <= dspent_d;
      dlimit_q   <= dlimit_d;
      retry_q    <= retry_d;
      motor_q    <= motor_d;
      pump_q     <= pump_d;
      active_q   <= active_d;
      paused_q   <= paused_d;
      finished_q <= finished_d;
      fault_q    <= fault_d;
      for (int i = 0; i < MAX_SPRINTS; i++) begin
        if (load_en && int'(entry_index_i) == i) begin
          on_tbl_q[i]  <= entry_on_ms_i;
          off_tbl_q[i] <= entry_off_ms_i;
        end
      end
    end
  end

  // result buffer control: output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_v_q;
  assign motor_run_o     = out_q.motor_run;
  assign pump_run_o      = out_q.pump_run;
  assign phase_o         = out_q.phase;
  assign active_o        = out_q.active;
  assign paused_o        = out_q.paused;
  assign finished_o      = out_q.finished;
  assign fault_o         = out_q.fault;
  assign monitor_clear_o = out_q.monitor_clear;

endmodule
